### hdl/hmmd_pkg.sv
// shared types, codes and address constants of the handheld memory map decoder
// no dependencies
package hmmd_pkg;

   // defaults for the top level parameters
   localparam int VIDEO_BANKS_DEF = 2;
   localparam int WORK_BANKS_DEF  = 8;

   // memory geometry
   localparam int VBANK_SIZE  = 8192;
   localparam int WBANK_SIZE  = 4096;
   localparam int SPRITE_SIZE = 160;
   localparam int HIGH_SIZE   = 127;

   // width of the memory address carried from front to back
   localparam int MADDR_W = 16;

   // result target codes
   localparam logic [2:0] TGT_INTERNAL = 3'd0;
   localparam logic [2:0] TGT_CART     = 3'd1;
   localparam logic [2:0] TGT_IO       = 3'd2;
   localparam logic [2:0] TGT_BOOT     = 3'd3;
   localparam logic [2:0] TGT_DMA      = 3'd4;
   localparam logic [2:0] TGT_DISCARD  = 3'd5;

   // display modes that matter for blocking
   localparam logic [1:0] MODE_OAM_SCAN = 2'd2;
   localparam logic [1:0] MODE_DRAW     = 2'd3;

   // open bus byte
   localparam logic [7:0] BYTE_OPEN = 8'hFF;

   // map boundaries
   localparam logic [15:0] ADDR_BOOT_END    = 16'h0100;
   localparam logic [15:0] ADDR_CBOOT_LO    = 16'h0200;
   localparam logic [15:0] ADDR_CBOOT_END   = 16'h0900;
   localparam logic [15:0] ADDR_CART_LAST   = 16'h7FFF;
   localparam logic [15:0] ADDR_VIDEO_LAST  = 16'h9FFF;
   localparam logic [15:0] ADDR_XRAM_FIRST  = 16'hA000;
   localparam logic [15:0] ADDR_XRAM_LAST   = 16'hBFFF;
   localparam logic [15:0] ADDR_ECHO_LAST   = 16'hFDFF;
   localparam logic [15:0] ADDR_SPRITE_LAST = 16'hFE9F;
   localparam logic [15:0] ADDR_UNUSED_LAST = 16'hFEFF;
   localparam logic [15:0] ADDR_OAM_DMA     = 16'hFF46;
   localparam logic [15:0] ADDR_BOOT_OFF    = 16'hFF50;
   localparam logic [15:0] ADDR_HDMA_FIRST  = 16'hFF51;
   localparam logic [15:0] ADDR_HDMA_LAST   = 16'hFF55;
   localparam logic [15:0] ADDR_IO_LAST     = 16'hFF7F;
   localparam logic [15:0] ADDR_HRAM_LAST   = 16'hFFFE;

   // configuration register index
   localparam logic REG_COLOR_MODE = 1'b0;

   typedef struct packed {
      logic        req_type;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [1:0]  ppu_mode;
      logic        lcd_enabled;
      logic        video_bank;
      logic [2:0]  work_bank;
   } access_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [2:0]  target;
      logic [15:0] forward_address;
      logic        blocked;
   } result_type;

   typedef enum logic [2:0] {
      OP_FIXED,
      OP_VIDEO,
      OP_WORK,
      OP_SPRITE,
      OP_HIGH,
      OP_IE
   } op_kind_type;

   // classified access waiting for the back end
   typedef struct packed {
      op_kind_type        kind;
      logic               wr;
      logic [7:0]         wdata;
      logic [MADDR_W-1:0] maddr;
      result_type         res;
   } op_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_stat_type;

   typedef enum logic {
      CLR_SWEEP,
      CLR_DONE
   } clear_state_type;

endpackage

### hdl/hmmd_front.sv
// front end: decodes one cpu access into an operation for the back end
// holds the boot overlay flag; depends on hmmd_pkg
module hmmd_front #(
   parameter int VIDEO_BANKS = hmmd_pkg::VIDEO_BANKS_DEF,
   parameter int WORK_BANKS  = hmmd_pkg::WORK_BANKS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                color_mode,
   input  logic                accept,
   input  hmmd_pkg::access_type req,
   output hmmd_pkg::op_type     op
);
   import hmmd_pkg::*;

   logic boot_overlay_ff;
   logic boot_overlay_in;
   logic wr;
   logic [15:0] a;
   logic vb;
   logic [2:0] wb;
   logic open_or_zero;

   // bank selection for the switched work ram window
   function automatic logic [2:0] pick_work_bank(input logic color, input logic [2:0] sel);
      logic [2:0] r;
      r = 3'd1;
      if (color) begin
         r = sel;
         for (int i = 0; i < 3; i++) begin
            if ({1'b0, r} >= 4'(WORK_BANKS)) begin
               r = r - 3'(WORK_BANKS);
            end
         end
         if (r == 3'd0) begin
            r = 3'd1;
         end
      end
      return r;
   endfunction

   assign wr = req.req_type;
   assign a  = req.address;
   assign vb = (VIDEO_BANKS > 1) ? (color_mode & req.video_bank) : 1'b0;
   assign wb = (a[12] == 1'b0) ? 3'd0 : pick_work_bank(color_mode, req.work_bank);
   assign open_or_zero = ~wr;

   always_comb begin
      op       = '0;
      op.kind  = OP_FIXED;
      op.wr    = wr;
      op.wdata = req.write_data;
      op.res.target = TGT_INTERNAL;
      if (!wr && boot_overlay_ff &&
          (a < ADDR_BOOT_END ||
           (color_mode && a >= ADDR_CBOOT_LO && a < ADDR_CBOOT_END))) begin
         op.res.target          = TGT_BOOT;
         op.res.forward_address = a;
      end else if (wr && a == ADDR_BOOT_OFF) begin
         op.kind = OP_FIXED;
      end else if (a <= ADDR_CART_LAST || (a >= ADDR_XRAM_FIRST && a <= ADDR_XRAM_LAST)) begin
         op.res.target          = TGT_CART;
         op.res.forward_address = a;
      end else if (a <= ADDR_VIDEO_LAST) begin
         if (req.lcd_enabled && req.ppu_mode == MODE_DRAW) begin
            op.res.blocked   = 1'b1;
            op.res.read_data = open_or_zero ? BYTE_OPEN : 8'h00;
         end else begin
            op.kind  = OP_VIDEO;
            op.maddr = MADDR_W'({vb, a[12:0]});
         end
      end else if (a <= ADDR_ECHO_LAST) begin
         // echo area folds onto the same 8 KiB window
         op.kind  = OP_WORK;
         op.maddr = MADDR_W'({wb, a[11:0]});
      end else if (a <= ADDR_SPRITE_LAST) begin
         if (req.lcd_enabled &&
             (req.ppu_mode == MODE_OAM_SCAN || req.ppu_mode == MODE_DRAW)) begin
            op.res.blocked   = 1'b1;
            op.res.read_data = open_or_zero ? BYTE_OPEN : 8'h00;
         end else begin
            op.kind  = OP_SPRITE;
            op.maddr = MADDR_W'(a[7:0]);
         end
      end else if (a <= ADDR_UNUSED_LAST) begin
         op.res.target    = TGT_DISCARD;
         op.res.read_data = open_or_zero ? BYTE_OPEN : 8'h00;
      end else if ((wr && (a == ADDR_OAM_DMA ||
                           (a >= ADDR_HDMA_FIRST && a <= ADDR_HDMA_LAST))) ||
                   (!wr && a == ADDR_HDMA_LAST)) begin
         op.res.target          = TGT_DMA;
         op.res.forward_address = a;
      end else if (a <= ADDR_IO_LAST) begin
         op.res.target          = TGT_IO;
         op.res.forward_address = a;
      end else if (a <= ADDR_HRAM_LAST) begin
         op.kind  = OP_HIGH;
         op.maddr = MADDR_W'(a[6:0]);
      end else begin
         op.kind = OP_IE;
      end
   end

   // overlay drops for good on a nonzero write to the boot-off register
   always_comb begin
      boot_overlay_in = boot_overlay_ff;
      if (accept && wr && a == ADDR_BOOT_OFF && req.write_data != 8'h00) begin
         boot_overlay_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         boot_overlay_ff <= 1'b1;
      end else begin
         boot_overlay_ff <= boot_overlay_in;
      end
   end

endmodule

### hdl/hmmd_queue.sv
// two-entry queue of decoded operations between front and back end
// depends on hmmd_pkg
module hmmd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  hmmd_pkg::queue_ctl_type ctl,
   input  hmmd_pkg::op_type        push_op,
   output hmmd_pkg::op_type        head_op,
   output hmmd_pkg::queue_stat_type stat
);
   import hmmd_pkg::*;

   op_type     slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign head_op    = slot_ff[rd_ptr_ff];
   assign stat.empty = (count_ff == 2'd0);
   assign stat.full  = (count_ff == 2'd2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (ctl.push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (ctl.pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (ctl.push && !ctl.pop) begin
         count_in = count_ff + 2'd1;
      end else if (!ctl.push && ctl.pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

### hdl/hmmd_back.sv
// back end: internal memories, clearing sweep after reset, result register
// depends on hmmd_pkg
module hmmd_back #(
   parameter int VIDEO_BANKS = hmmd_pkg::VIDEO_BANKS_DEF,
   parameter int WORK_BANKS  = hmmd_pkg::WORK_BANKS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 have_op,
   input  hmmd_pkg::op_type     head_op,
   output logic                 take_op,
   output logic                 clearing,
   output logic                 rsp_strobe,
   output hmmd_pkg::result_type rsp_data
);
   import hmmd_pkg::*;

   localparam int VIDEO_DEPTH = VIDEO_BANKS * VBANK_SIZE;
   localparam int WORK_DEPTH  = WORK_BANKS * WBANK_SIZE;
   localparam int CLEAR_LEN   = (VIDEO_DEPTH > WORK_DEPTH) ? VIDEO_DEPTH : WORK_DEPTH;
   localparam int VAW = $clog2(VIDEO_DEPTH);
   localparam int WAW = $clog2(WORK_DEPTH);
   localparam int SAW = $clog2(SPRITE_SIZE);
   localparam int HAW = $clog2(HIGH_SIZE);
   localparam int CLW = $clog2(CLEAR_LEN);

   logic [7:0] video_mem  [VIDEO_DEPTH];
   logic [7:0] work_mem   [WORK_DEPTH];
   logic [7:0] sprite_mem [SPRITE_SIZE];
   logic [7:0] high_mem   [HIGH_SIZE];

   clear_state_type state_ff;
   clear_state_type state_in;
   logic [CLW-1:0]  clr_cnt_ff;
   logic [CLW-1:0]  clr_cnt_in;

   logic [7:0]  ie_ff;
   logic [7:0]  ie_in;
   logic [7:0]  video_q_ff;
   logic [7:0]  work_q_ff;
   logic [7:0]  sprite_q_ff;
   logic [7:0]  high_q_ff;
   logic [7:0]  ie_q_ff;

   logic        rsp_valid_ff;
   result_type  rsp_res_ff;
   op_kind_type rsp_kind_ff;
   logic        rsp_wr_ff;

   logic clr_video;
   logic clr_work;
   logic clr_sprite;
   logic clr_high;

   // clear sweep state machine
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CLR_SWEEP: begin
            if (clr_cnt_ff == CLW'(CLEAR_LEN - 1)) begin
               state_in = CLR_DONE;
            end
         end
         CLR_DONE: begin
            state_in = CLR_DONE;
         end
         default: begin
            state_in = CLR_SWEEP;
         end
      endcase
   end

   always_comb begin
      clearing   = 1'b0;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         CLR_SWEEP: begin
            clearing   = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         CLR_DONE: begin
            clearing = 1'b0;
         end
         default: begin
            clearing = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= CLR_SWEEP;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign take_op = have_op & ~clearing;

   assign clr_video  = clearing && ({1'b0, clr_cnt_ff} < (CLW + 1)'(VIDEO_DEPTH));
   assign clr_work   = clearing && ({1'b0, clr_cnt_ff} < (CLW + 1)'(WORK_DEPTH));
   assign clr_sprite = clearing && ({1'b0, clr_cnt_ff} < (CLW + 1)'(SPRITE_SIZE));
   assign clr_high   = clearing && ({1'b0, clr_cnt_ff} < (CLW + 1)'(HIGH_SIZE));

   // memories: read first, write on write access
   always_ff @(posedge clock) begin
      if (clr_video) begin
         video_mem[clr_cnt_ff[VAW-1:0]] <= 8'h00;
      end else if (take_op && head_op.kind == OP_VIDEO) begin
         video_q_ff <= video_mem[head_op.maddr[VAW-1:0]];
         if (head_op.wr) begin
            video_mem[head_op.maddr[VAW-1:0]] <= head_op.wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_work) begin
         work_mem[clr_cnt_ff[WAW-1:0]] <= 8'h00;
      end else if (take_op && head_op.kind == OP_WORK) begin
         work_q_ff <= work_mem[head_op.maddr[WAW-1:0]];
         if (head_op.wr) begin
            work_mem[head_op.maddr[WAW-1:0]] <= head_op.wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_sprite) begin
         sprite_mem[clr_cnt_ff[SAW-1:0]] <= 8'h00;
      end else if (take_op && head_op.kind == OP_SPRITE) begin
         sprite_q_ff <= sprite_mem[head_op.maddr[SAW-1:0]];
         if (head_op.wr) begin
            sprite_mem[head_op.maddr[SAW-1:0]] <= head_op.wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_high) begin
         high_mem[clr_cnt_ff[HAW-1:0]] <= 8'h00;
      end else if (take_op && head_op.kind == OP_HIGH) begin
         high_q_ff <= high_mem[head_op.maddr[HAW-1:0]];
         if (head_op.wr) begin
            high_mem[head_op.maddr[HAW-1:0]] <= head_op.wdata;
         end
      end
   end

   // interrupt enable byte
   always_comb begin
      ie_in = ie_ff;
      if (take_op && head_op.kind == OP_IE && head_op.wr) begin
         ie_in = head_op.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ie_ff <= 8'h00;
      end else begin
         ie_ff <= ie_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_op) begin
         ie_q_ff     <= ie_ff;
         rsp_res_ff  <= head_op.res;
         rsp_kind_ff <= head_op.kind;
         rsp_wr_ff   <= head_op.wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= take_op;
      end
   end

   assign rsp_strobe = rsp_valid_ff;

   always_comb begin
      rsp_data = rsp_res_ff;
      if (!rsp_wr_ff) begin
         unique case (rsp_kind_ff)
            OP_FIXED:  rsp_data.read_data = rsp_res_ff.read_data;
            OP_VIDEO:  rsp_data.read_data = video_q_ff;
            OP_WORK:   rsp_data.read_data = work_q_ff;
            OP_SPRITE: rsp_data.read_data = sprite_q_ff;
            OP_HIGH:   rsp_data.read_data = high_q_ff;
            OP_IE:     rsp_data.read_data = ie_q_ff;
            default:   rsp_data.read_data = rsp_res_ff.read_data;
         endcase
      end
   end

endmodule

### hdl/handheld_memory_map_decoder.sv
// top level of the handheld memory map decoder: config register, front end,
// queue and back end; depends on hmmd_pkg, hmmd_front, hmmd_queue, hmmd_back
//
// usage
// - command channel: drive req_data and raise start; the word is taken at a
//   rising edge where start is high and busy is low
// - result channel: each word yields exactly one result, shown on rsp_data
//   for one cycle with rsp_strobe high; the receiver cannot stall it
// - apb port: one register, color_mode at byte address 0; pready is tied
//   high, reads return the register value
// - path: a taken word is decoded and written into a queue slot, the back end
//   then performs the ram access from the queue head and registers the result
//   and rsp_strobe, and the result is shown from those registers
// - throughput: one word per cycle outside the clear sweep, set by the single port of each ram
//   (one read-or-write per cycle); the two-entry queue raises busy if it
//   ever fills
// - reset: all rams are swept to zero, one entry per cycle in parallel, until
//   the largest ram is covered; busy stays high meanwhile, config writes still
//   work
// - reset also sets the boot overlay, clears the interrupt enable byte and
//   color_mode
module handheld_memory_map_decoder #(
   parameter int VIDEO_BANKS = hmmd_pkg::VIDEO_BANKS_DEF,
   parameter int WORK_BANKS  = hmmd_pkg::WORK_BANKS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // command channel
   input  logic                 start,
   output logic                 busy,
   input  hmmd_pkg::access_type req_data,
   // result channel
   output logic                 rsp_strobe,
   output hmmd_pkg::result_type rsp_data,
   // apb configuration port
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import hmmd_pkg::*;

   logic           color_mode_ff;
   logic           color_mode_in;
   logic           csr_write;
   logic           accept;
   logic           clearing;
   logic           take_op;
   op_type         front_op;
   op_type         head_op;
   queue_ctl_type  q_ctl;
   queue_stat_type q_stat;

   // apb: no wait states in the access phase, register index from the word address
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      color_mode_in = color_mode_ff;
      if (csr_write && paddr[2] == REG_COLOR_MODE) begin
         color_mode_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= 1'b0;
      end else begin
         color_mode_ff <= color_mode_in;
      end
   end

   assign prdata = (paddr[2] == REG_COLOR_MODE) ? {31'd0, color_mode_ff} : 32'd0;

   // hold off new words during the clear sweep or when the queue is full
   assign busy   = clearing | q_stat.full;
   assign accept = start & ~busy;

   assign q_ctl.push = accept;
   assign q_ctl.pop  = take_op;

   hmmd_front #(
      .VIDEO_BANKS (VIDEO_BANKS),
      .WORK_BANKS  (WORK_BANKS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .color_mode (color_mode_ff),
      .accept     (accept),
      .req        (req_data),
      .op         (front_op)
   );

   hmmd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .ctl     (q_ctl),
      .push_op (front_op),
      .head_op (head_op),
      .stat    (q_stat)
   );

   hmmd_back #(
      .VIDEO_BANKS (VIDEO_BANKS),
      .WORK_BANKS  (WORK_BANKS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .have_op    (~q_stat.empty),
      .head_op    (head_op),
      .take_op    (take_op),
      .clearing   (clearing),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
